### src/rdeh_pkg.sv
// Package: widths, types and register codes of the ellipse diagonal hit test
`default_nettype none
package rdeh_pkg;

  // coordinate width of registers and item fields
  localparam int CW   = 16;
  // doubled, centered start point (px, py)
  localparam int PW   = CW + 3;
  // doubled direction (bx, by)
  localparam int DW   = CW + 2;
  // squared ellipse size (rx, ry)
  localparam int RW   = 2 * CW - 1;
  // bx*bx, bx*px, px*px (last one trimmed to its value range)
  localparam int SW   = 2 * DW;
  localparam int XW   = DW + PW;
  localparam int P2W  = 2 * PW - 1;
  // rx*ry
  localparam int RRW  = 2 * RW;
  // quadratic coefficients a, b, c and a+b
  localparam int QW   = P2W + RW;
  // half word of the split wide multiplier
  localparam int HW   = QW / 2;
  // middle partial-product sum
  localparam int MW   = 2 * HW + 2;
  // full wide products
  localparam int PRW  = 2 * QW;
  // pipeline stages that carry a valid bit before the final hit register
  localparam int NSTG = 9;
  // config register index width
  localparam int IDXW = 2;

  typedef enum logic [IDXW-1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_e;

  // one diagonal: start offset from center and direction, doubled units
  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [DW-1:0] bx;
    logic signed [DW-1:0] by;
  } seg_t;

  // sign tests of the coefficients used by the root-range decision
  typedef struct packed {
    logic qb_le0;
    logic qc_ge0;
    logic qc_le0;
    logic ab_ge0;
  } qflags_t;

endpackage
`default_nettype wire

### src/rdeh_if.sv
// Valid/ready interfaces for query items and hit results
`default_nettype none
interface rdeh_in_if import rdeh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] query_left;
  logic signed [CW-1:0] query_top;
  logic signed [CW-1:0] query_width;
  logic signed [CW-1:0] query_height;

  modport source (output valid, query_left, query_top, query_width, query_height,
                  input ready);
  modport sink   (input valid, query_left, query_top, query_width, query_height,
                  output ready);
endinterface

interface rdeh_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface
`default_nettype wire

### src/rect_diagonal_ellipse_hit_core.sv
// Top level: config registers, segment setup, lanes, hit register, output skid
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------------
//  in_i     | in  | valid / ready        | query_left, query_top, query_width, height
//  out_o    | out | valid / ready        | hit
//  cfg      | in  | cfg_we_i, no wait    | cfg_idx_i, cfg_data_i
//
// One item per cycle while the skid is empty; a result leaves through the final hit register and the output register.
// The depth is set by the coefficient multiplies and the split wide multiplier.
// Reset clears the config registers, every valid bit and the output skid.
// When out_o stalls, one result parks in the skid register; only then does
// in_i.ready drop, and the whole pipe holds until the skid drains.
`default_nettype none
module rect_diagonal_ellipse_hit_core import rdeh_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [IDXW-1:0]       cfg_idx_i,
  input  wire [CW-1:0]         cfg_data_i,
  rdeh_in_if.sink              in_i,
  rdeh_out_if.source           out_o
);

  // config registers
  logic signed [CW-1:0] el_q, et_q, ew_q, eh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_q <= '0;
      et_q <= '0;
      ew_q <= '0;
      eh_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_LEFT:   el_q <= $signed(cfg_data_i);
        REG_TOP:    et_q <= $signed(cfg_data_i);
        REG_WIDTH:  ew_q <= $signed(cfg_data_i);
        REG_HEIGHT: eh_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // pipe advances whenever the skid is empty
  logic en;
  logic sk_v_q, sk_hit_q, out_v_q, out_hit_q;

  assign en          = !sk_v_q;
  assign in_i.ready  = en;

  // stage 1: doubled, centered segments and squared ellipse size
  logic signed [PW-1:0]   cx, cy, py;
  logic signed [DW-1:0]   bx0, by0;
  logic signed [2*CW-1:0] ew2, eh2;
  logic                   ok;
  seg_t                   seg0_d, seg1_d, seg0_q, seg1_q;
  logic signed [RW-1:0]   rx_q, ry_q;

  always_comb begin
    cx  = (PW'(el_q) <<< 1) + PW'(ew_q);
    cy  = (PW'(et_q) <<< 1) + PW'(eh_q);
    py  = (PW'(in_i.query_top) <<< 1) - cy;
    bx0 = DW'(in_i.query_width) <<< 1;
    by0 = DW'(in_i.query_height) <<< 1;
    // top-left to bottom-right
    seg0_d.px = (PW'(in_i.query_left) <<< 1) - cx;
    seg0_d.py = py;
    seg0_d.bx = bx0;
    seg0_d.by = by0;
    // top-right to bottom-left
    seg1_d.px = ((PW'(in_i.query_left) + PW'(in_i.query_width)) <<< 1) - cx;
    seg1_d.py = py;
    seg1_d.bx = -bx0;
    seg1_d.by = by0;
    ok = !ew_q[CW-1] && (ew_q != '0) && !eh_q[CW-1] && (eh_q != '0) &&
         !in_i.query_width[CW-1] && (in_i.query_width != '0) &&
         !in_i.query_height[CW-1] && (in_i.query_height != '0);
  end

  assign ew2 = ew_q * ew_q;
  assign eh2 = eh_q * eh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      seg0_q <= seg0_d;
      seg1_q <= seg1_d;
      rx_q   <= $signed(ew2[RW-1:0]);
      ry_q   <= $signed(eh2[RW-1:0]);
    end
  end

  // valid and validity flags travel with the data
  logic vld_q [NSTG];
  logic ok_q  [NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) begin
        vld_q[i] <= 1'b0;
        ok_q[i]  <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      ok_q[0]  <= ok;
      for (int i = 1; i < NSTG; i++) begin
        vld_q[i] <= vld_q[i-1];
        ok_q[i]  <= ok_q[i-1];
      end
    end
  end

  // the two diagonals
  logic hit0, hit1;

  rdeh_lane u_lane0 (
    .clk_i (clk_i), .en_i (en), .seg_i (seg0_q), .rx_i (rx_q), .ry_i (ry_q), .hit_o (hit0)
  );
  rdeh_lane u_lane1 (
    .clk_i (clk_i), .en_i (en), .seg_i (seg1_q), .rx_i (rx_q), .ry_i (ry_q), .hit_o (hit1)
  );

  // final hit register
  logic fin_v_q, fin_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_hit_q <= ok_q[NSTG-1] && (hit0 || hit1);
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (out_o.ready) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end
    end else if (!out_v_q || out_o.ready) begin
      out_v_q <= fin_v_q;
    end else if (fin_v_q) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (out_o.ready) out_hit_q <= sk_hit_q;
    end else if (!out_v_q || out_o.ready) begin
      out_hit_q <= fin_hit_q;
    end else begin
      sk_hit_q <= fin_hit_q;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.hit   = out_hit_q;

endmodule
`default_nettype wire

### src/rdeh_coef.sv
// Quadratic coefficients a, b, c and a+b for one diagonal, four stages
`default_nettype none
module rdeh_coef import rdeh_pkg::*; (
  input  wire                   clk_i,
  input  wire                   en_i,
  input  wire seg_t             seg_i,
  input  wire logic signed [RW-1:0] rx_i,
  input  wire logic signed [RW-1:0] ry_i,
  output logic signed [QW-1:0]  qa_o,
  output logic signed [QW-1:0]  qb_o,
  output logic signed [QW-1:0]  qc_o,
  output logic signed [QW-1:0]  ab_o
);

  // stage 2: squares and cross terms of the segment
  logic signed [2*PW-1:0] px2_full, py2_full;
  logic signed [SW-1:0]   bx2_q, by2_q;
  logic signed [XW-1:0]   bxpx_q, bypy_q;
  logic signed [P2W-1:0]  px2_q, py2_q;
  logic signed [RRW-1:0]  rxry_q2, rxry_q3;
  logic signed [RW-1:0]   rx_q2, ry_q2;

  assign px2_full = seg_i.px * seg_i.px;
  assign py2_full = seg_i.py * seg_i.py;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bx2_q   <= seg_i.bx * seg_i.bx;
      by2_q   <= seg_i.by * seg_i.by;
      bxpx_q  <= seg_i.bx * seg_i.px;
      bypy_q  <= seg_i.by * seg_i.py;
      px2_q   <= $signed(px2_full[P2W-1:0]);
      py2_q   <= $signed(py2_full[P2W-1:0]);
      rxry_q2 <= rx_i * ry_i;
      rx_q2   <= rx_i;
      ry_q2   <= ry_i;
    end
  end

  // stage 3: scale by the squared ellipse sizes
  logic signed [SW+RW-1:0]  t_ax_q, t_ay_q;
  logic signed [XW+RW-1:0]  t_bx_q, t_by_q;
  logic signed [P2W+RW-1:0] t_cx_q, t_cy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_ax_q  <= bx2_q * ry_q2;
      t_ay_q  <= by2_q * rx_q2;
      t_bx_q  <= bxpx_q * ry_q2;
      t_by_q  <= bypy_q * rx_q2;
      t_cx_q  <= px2_q * ry_q2;
      t_cy_q  <= py2_q * rx_q2;
      rxry_q3 <= rxry_q2;
    end
  end

  // stage 4: coefficient sums
  logic signed [QW-1:0] qa_q4, qb_q4, qc_q4;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qa_q4 <= QW'(t_ax_q) + QW'(t_ay_q);
      qb_q4 <= QW'(t_bx_q) + QW'(t_by_q);
      qc_q4 <= QW'(t_cx_q) + QW'(t_cy_q) - QW'(rxry_q3);
    end
  end

  // stage 5: a+b, with a, b and c registered alongside
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qa_o <= qa_q4;
      qb_o <= qb_q4;
      qc_o <= qc_q4;
      ab_o <= qa_q4 + qb_q4;
    end
  end

endmodule
`default_nettype wire

### src/rdeh_wmul.sv
// Wide signed multiplier from four half-word products, three stages
`default_nettype none
module rdeh_wmul import rdeh_pkg::*; (
  input  wire                       clk_i,
  input  wire                       en_i,
  input  wire logic signed [QW-1:0] a_i,
  input  wire logic signed [QW-1:0] b_i,
  output logic signed [PRW-1:0]     p_o
);

  logic signed [HW:0]   a_lo, b_lo;
  logic signed [HW-1:0] a_hi, b_hi;

  // low halves are unsigned, high halves carry the sign
  assign a_lo = $signed({1'b0, a_i[HW-1:0]});
  assign b_lo = $signed({1'b0, b_i[HW-1:0]});
  assign a_hi = $signed(a_i[QW-1:HW]);
  assign b_hi = $signed(b_i[QW-1:HW]);

  // stage 1: partial products
  logic signed [MW-1:0]   ll_q;
  logic signed [2*HW:0]   lh_q, hl_q;
  logic signed [2*HW-1:0] hh_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_lo * b_lo;
      lh_q <= a_lo * b_hi;
      hl_q <= a_hi * b_lo;
      hh_q <= a_hi * b_hi;
    end
  end

  // stage 2: middle terms
  logic signed [MW-1:0]   mid_q, ll2_q;
  logic signed [2*HW-1:0] hh2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= MW'(lh_q) + MW'(hl_q);
      ll2_q <= ll_q;
      hh2_q <= hh_q;
    end
  end

  // stage 3: aligned sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= (PRW'(hh2_q) <<< (2 * HW)) + (PRW'(mid_q) <<< HW) + PRW'(ll2_q);
    end
  end

endmodule
`default_nettype wire

### src/rdeh_lane.sv
// One diagonal: coefficients, discriminant and root-in-range decision
`default_nettype none
module rdeh_lane import rdeh_pkg::*; (
  input  wire                       clk_i,
  input  wire                       en_i,
  input  wire seg_t                 seg_i,
  input  wire logic signed [RW-1:0] rx_i,
  input  wire logic signed [RW-1:0] ry_i,
  output logic                      hit_o
);

  logic signed [QW-1:0]  qa, qb, qc, ab;
  logic signed [PRW-1:0] b2, ac, ab2;

  rdeh_coef u_coef (
    .clk_i (clk_i),
    .en_i  (en_i),
    .seg_i (seg_i),
    .rx_i  (rx_i),
    .ry_i  (ry_i),
    .qa_o  (qa),
    .qb_o  (qb),
    .qc_o  (qc),
    .ab_o  (ab)
  );

  rdeh_wmul u_mul_bb (.clk_i(clk_i), .en_i(en_i), .a_i(qb), .b_i(qb), .p_o(b2));
  rdeh_wmul u_mul_ac (.clk_i(clk_i), .en_i(en_i), .a_i(qa), .b_i(qc), .p_o(ac));
  rdeh_wmul u_mul_ab (.clk_i(clk_i), .en_i(en_i), .a_i(ab), .b_i(ab), .p_o(ab2));

  // sign tests, delayed to line up with the wide products
  qflags_t flg_d;
  qflags_t flg_q [4];

  always_comb begin
    flg_d.qb_le0 = qb[QW-1] || (qb == '0);
    flg_d.qc_ge0 = !qc[QW-1];
    flg_d.qc_le0 = qc[QW-1] || (qc == '0);
    flg_d.ab_ge0 = !ab[QW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flg_q[0] <= flg_d;
      flg_q[1] <= flg_q[0];
      flg_q[2] <= flg_q[1];
      flg_q[3] <= flg_q[2];
    end
  end

  // discriminant b^2 - a*c
  logic signed [PRW-1:0] disc_q, ab2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      disc_q <= b2 - ac;
      ab2_q  <= ab2;
    end
  end

  // compare disc with (a+b)^2 in place of the square root
  logic signed [PRW:0] cmp;
  logic                d_ge, d_le, lo_root, hi_root;

  assign cmp  = (PRW+1)'(disc_q) - (PRW+1)'(ab2_q);
  assign d_ge = !cmp[PRW];
  assign d_le = cmp[PRW] || (cmp == '0);

  always_comb begin
    lo_root = flg_q[3].qb_le0 && flg_q[3].qc_ge0 && (flg_q[3].ab_ge0 || d_ge);
    hi_root = (flg_q[3].qb_le0 || flg_q[3].qc_le0) && flg_q[3].ab_ge0 && d_le;
    hit_o   = !disc_q[PRW-1] && (lo_root || hi_root);
  end

endmodule
`default_nettype wire

### src/rdeh_chk.sv
// Port-level checker for the hit core, attached by bind
`default_nettype none
module rdeh_chk (
  input wire clk_i,
  input wire rst_ni,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire out_hit_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_hit_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_hit_i))
    else $error("result changed while stalled");

  // input only backs off while a result is waiting
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  // one taken result frees the input side
  a_ready_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i && out_ready_i |=> in_ready_i)
    else $error("input stayed stalled after output drained");

endmodule

bind rect_diagonal_ellipse_hit_core rdeh_chk u_rdeh_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_hit_i   (out_o.hit)
);
`default_nettype wire
